FILE: design/svo_pkg.sv
// ----------------------------------------------------------------------------
// svo_pkg
// Shared types, sizes and helpers for the sparse voxel octree insert unit.
// ----------------------------------------------------------------------------
package svo_pkg;

   localparam int TREE_DEPTH  = 5;
   localparam int NODE_POOL   = 8192;
   localparam int COORD_W     = 5;
   localparam int COLOR_W     = 16;
   localparam int PTR_W       = 16;
   localparam int NODES_OUT_W = 14;
   localparam int LEAVES_W    = 16;
   localparam int OCT_W       = 3;
   localparam int ROW_W       = 8;

   localparam int NODE_W     = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
   localparam int SLOT_W     = NODE_W + OCT_W;
   localparam int SLOT_COUNT = NODE_POOL * ROW_W;
   localparam int CNT_W      = $clog2(NODE_POOL + 1);
   localparam int LEVEL_W    = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
   localparam int PTR_CMP_W  = PTR_W + 1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic [COLOR_W-1:0] leaf_color;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [NODES_OUT_W-1:0] nodes_used;
      logic [LEAVES_W-1:0]    leaf_count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic rd;
      logic eval;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_done;
      logic rsp_free;
   } stat_type;

   // coordinate bit for a tree level, zero above the top coordinate bit
   function automatic logic coord_bit(logic [COORD_W-1:0] v, logic [LEVEL_W-1:0] lvl);
      logic [COORD_W-1:0] s;
      s = v >> lvl;
      return s[0];
   endfunction

endpackage

FILE: design/svo_ctrl.sv
// ----------------------------------------------------------------------------
// svo_ctrl
// Sequencer for the octree walk: accept, read/evaluate per level, deliver.
// ----------------------------------------------------------------------------
module svo_ctrl
   import svo_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type sts,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.walk_done ? S_DONE : S_READ;
         end
         S_DONE: begin
            // wait for the result register to be free
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: design/svo_dpath.sv
// ----------------------------------------------------------------------------
// svo_dpath
// Node memories, walk registers, counters and the result register.
// ----------------------------------------------------------------------------
module svo_dpath
   import svo_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type sts,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   // active marks one row per node, child pointers one entry per slot
   logic [ROW_W-1:0] row_mem [NODE_POOL];
   logic [PTR_W-1:0] ptr_mem [SLOT_COUNT];

   req_type             req_ff;
   logic [NODE_W-1:0]   node_ff;
   logic [NODE_W-1:0]   node_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic                fresh_ff;
   logic                fresh_in;
   status_type          status_ff;
   status_type          status_in;
   logic [CNT_W-1:0]    node_count_ff;
   logic [CNT_W-1:0]    node_count_in;
   logic [LEAVES_W-1:0] leaves_ff;
   logic [LEAVES_W-1:0] leaves_in;
   logic [ROW_W-1:0]    root_row_ff;
   logic [ROW_W-1:0]    row_rd_ff;
   logic [PTR_W-1:0]    ptr_rd_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [OCT_W-1:0]         oct;
   logic [SLOT_W-1:0]        slot;
   logic [NODE_W-1:0]        fresh_node;
   logic [ROW_W-1:0]         row_eff;
   logic [ROW_W-1:0]         onehot;
   logic [ROW_W-1:0]         row_wdata;
   logic [PTR_W-1:0]         ptr_wdata;
   logic [PTR_CMP_W-1:0]     ptr_wide;
   logic [CNT_W+NODES_OUT_W-1:0] cnt_ext;
   logic active;
   logic at_leaf;
   logic pool_full;
   logic ptr_bad;
   logic set_bit;
   logic alloc;
   logic leaf_add;
   logic walk_done;
   logic row_we;

   assign oct = {coord_bit(req_ff.pos_x, level_ff),
                 coord_bit(req_ff.pos_y, level_ff),
                 coord_bit(req_ff.pos_z, level_ff)};
   assign slot       = {node_ff, oct};
   assign fresh_node = node_count_ff[NODE_W-1:0];
   assign cnt_ext    = {{NODES_OUT_W{1'b0}}, node_count_ff};

   always_comb begin
      // a node allocated on the previous level has no marks yet
      if (node_ff == '0) begin
         row_eff = root_row_ff;
      end else if (fresh_ff) begin
         row_eff = '0;
      end else begin
         row_eff = row_rd_ff;
      end
      onehot    = ROW_W'(1) << oct;
      active    = row_eff[oct];
      at_leaf   = (level_ff == '0);
      pool_full = (node_count_ff == CNT_W'(NODE_POOL));
      ptr_wide  = {1'b0, ptr_rd_ff};
      ptr_bad   = (ptr_wide >= PTR_CMP_W'(NODE_POOL));

      set_bit   = 1'b0;
      alloc     = 1'b0;
      leaf_add  = 1'b0;
      walk_done = 1'b0;
      status_in = status_ff;
      node_in   = node_ff;
      fresh_in  = fresh_ff;

      priority if (at_leaf) begin
         walk_done = 1'b1;
         if (!active) begin
            set_bit   = 1'b1;
            leaf_add  = 1'b1;
            status_in = ST_INSERTED;
         end else begin
            status_in = ST_DUPLICATE;
         end
      end else if (!active) begin
         if (pool_full) begin
            walk_done = 1'b1;
            status_in = ST_EXHAUSTED;
         end else begin
            set_bit  = 1'b1;
            alloc    = 1'b1;
            node_in  = fresh_node;
            fresh_in = 1'b1;
         end
      end else if (ptr_bad) begin
         walk_done = 1'b1;
         status_in = ST_EXHAUSTED;
      end else begin
         node_in  = ptr_rd_ff[NODE_W-1:0];
         fresh_in = 1'b0;
      end

      // a fresh row is always written so later walks never see stale marks
      row_we    = fresh_ff | set_bit;
      row_wdata = row_eff | (set_bit ? onehot : '0);
      ptr_wdata = alloc ? PTR_W'(fresh_node) : req_ff.leaf_color;

      node_count_in = alloc ? node_count_ff + CNT_W'(1) : node_count_ff;
      leaves_in     = (leaf_add && (leaves_ff != '1)) ? leaves_ff + LEAVES_W'(1)
                                                      : leaves_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         row_rd_ff <= row_mem[node_ff];
         ptr_rd_ff <= ptr_mem[slot];
      end
      if (cmd.eval && row_we && (node_ff != '0)) begin
         row_mem[node_ff] <= row_wdata;
      end
      if (cmd.eval && set_bit) begin
         ptr_mem[slot] <= ptr_wdata;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff    <= req_data;
         node_ff   <= '0;
         level_ff  <= LEVEL_W'(TREE_DEPTH - 1);
         fresh_ff  <= 1'b0;
         status_ff <= ST_INSERTED;
      end else if (cmd.eval) begin
         node_ff   <= node_in;
         fresh_ff  <= fresh_in;
         status_ff <= status_in;
         if (!walk_done) begin
            level_ff <= level_ff - LEVEL_W'(1);
         end
      end
      if (cmd.finish) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.nodes_used <= cnt_ext[NODES_OUT_W-1:0];
         rsp_ff.leaf_count <= leaves_ff;
      end
   end

   // tree state and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_W'(1);
         leaves_ff     <= '0;
         root_row_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.eval) begin
            node_count_ff <= node_count_in;
            leaves_ff     <= leaves_in;
            if (row_we && (node_ff == '0)) begin
               root_row_ff <= row_wdata;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts       = {walk_done, (!rsp_valid_ff || rsp_ready)};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/sparse_voxel_octree_insert_unit.sv
// ----------------------------------------------------------------------------
// sparse_voxel_octree_insert_unit
// Inserts voxels into a five-level sparse octree over a 32x32x32 chunk.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req_data) carries x, y, z and a color
// index; the response channel (rsp_valid/rsp_ready/rsp_data) returns one
// status word per request: inserted, duplicate or pool exhausted, plus the
// node count and filled leaf count after the insert.
// Each tree level first reads the node's active-mark row and the slot's child
// pointer, then decides and writes back. A full walk is 5 levels; a new
// request is taken only once the previous walk has delivered its result,
// and an insert that runs out of pool stops early and skips the remaining
// levels.
// The walk is bound by the single read port of the node memories.
// The result sits in an output register, so the next request is taken while
// an earlier response still waits; if the receiver stalls that long, the
// finished walk holds until the register frees.
// Reset empties the tree (root only, no leaves): only the root's marks are
// flip-flops, every other node row is written when it is allocated.
// ----------------------------------------------------------------------------
module sparse_voxel_octree_insert_unit
   import svo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type sts;

   svo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   svo_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sparse voxel octree insert unit against a behavioral tree model.
// Requests are sent in random bursts. Responses are taken with random stalls
// and one long hold-off. Every response is compared field by field with the
// outcome that the local octree model predicts for the accepted request.
// ----------------------------------------------------------------------------
module testbench;
   import svo_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sparse_voxel_octree_insert_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // local copy of the tree: one active mark and one pointer per child slot
   bit                slot_active  [SLOT_COUNT];
   logic [PTR_W-1:0]  slot_pointer [SLOT_COUNT];
   int unsigned       tree_nodes  = 1;
   int unsigned       tree_leaves = 0;

   rsp_type insert_outcomes [$];
   req_type filled_spots [$];

   int error_count    = 0;
   int request_count  = 0;
   int inserted_count = 0;
   int dup_count      = 0;
   int exhaust_count  = 0;
   int stall_cycles   = 0;

   bit idle_on      = 1'b1;
   int burst_left   = 0;
   int hold_request = 0;
   int hold_left    = 0;
   int ready_run    = 0;
   bit ready_level  = 1'b1;

   task automatic report_mismatch(input string msg);
      if (error_count < 100)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // walks the tree from the root, allocating missing inner nodes
   function automatic rsp_type predict_insert(input req_type r);
      rsp_type     res;
      status_type  st;
      int unsigned node;
      int unsigned slot;
      int          lvl;
      bit          stop;
      st   = ST_INSERTED;
      node = 0;
      stop = 1'b0;
      lvl  = TREE_DEPTH - 1;
      while (!stop && lvl >= 0) begin
         slot = node * ROW_W + {r.pos_x[lvl], r.pos_y[lvl], r.pos_z[lvl]};
         if (slot >= SLOT_COUNT) begin
            st   = ST_EXHAUSTED;
            stop = 1'b1;
         end else if (lvl > 0) begin
            if (!slot_active[slot]) begin
               if (tree_nodes >= NODE_POOL) begin
                  st   = ST_EXHAUSTED;
                  stop = 1'b1;
               end else begin
                  for (int i = 0; i < ROW_W; i++)
                     slot_active[tree_nodes * ROW_W + i] = 1'b0;
                  slot_active[slot]  = 1'b1;
                  slot_pointer[slot] = tree_nodes[PTR_W-1:0];
                  node = tree_nodes;
                  tree_nodes++;
               end
            end else begin
               node = slot_pointer[slot];
               if (node >= NODE_POOL) begin
                  st   = ST_EXHAUSTED;
                  stop = 1'b1;
               end
            end
         end else begin
            if (!slot_active[slot]) begin
               slot_active[slot]  = 1'b1;
               slot_pointer[slot] = r.leaf_color;
               if (tree_leaves < 16'hFFFF)
                  tree_leaves++;
            end else begin
               st = ST_DUPLICATE;
            end
         end
         lvl--;
      end
      res.status     = st;
      res.nodes_used = tree_nodes[NODES_OUT_W-1:0];
      res.leaf_count = tree_leaves[LEAVES_W-1:0];
      return res;
   endfunction

   // offers one voxel and waits until it is taken; bursts end in idle gaps
   task automatic push_voxel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic [COLOR_W-1:0] color);
      req_type item;
      rsp_type want;
      int      gap;
      item.pos_x      = x;
      item.pos_y      = y;
      item.pos_z      = z;
      item.leaf_color = color;
      if (idle_on) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      want = predict_insert(item);
      insert_outcomes = {insert_outcomes, want};
      request_count++;
      case (want.status)
         ST_INSERTED: begin
            inserted_count++;
            filled_spots = {filled_spots, item};
         end
         ST_DUPLICATE: dup_count++;
         default:      exhaust_count++;
      endcase
   endtask

   // response check
   always @(posedge clock) begin : check_blk
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (insert_outcomes.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = insert_outcomes.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.nodes_used !== want.nodes_used)
               report_mismatch($sformatf("nodes_used got %0d want %0d",
                                         rsp_data.nodes_used, want.nodes_used));
            if (rsp_data.leaf_count !== want.leaf_count)
               report_mismatch($sformatf("leaf_count got %0d want %0d",
                                         rsp_data.leaf_count, want.leaf_count));
         end
      end
      if (!reset && req_valid && !req_ready)
         stall_cycles++;
   end

   // response side: random stall runs, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!idle_on) begin
            rsp_ready <= 1'b1;
         end else begin
            if (ready_run == 0) begin
               ready_level = ($urandom_range(0, 2) != 0);
               ready_run   = ready_level ? $urandom_range(1, 30) : $urandom_range(1, 20);
            end
            ready_run--;
            rsp_ready <= ready_level;
         end
      end
   end

   // corners of the chunk, repeated corner voxels, and single coordinate bits
   task automatic test_corners();
      for (int c = 0; c < 8; c++)
         push_voxel(c[2] ? 5'd31 : 5'd0, c[1] ? 5'd31 : 5'd0, c[0] ? 5'd31 : 5'd0,
                    c[0] ? 16'hFFFF : 16'h0000);
      push_voxel(5'd0, 5'd0, 5'd0, 16'hFFFF);
      push_voxel(5'd31, 5'd31, 5'd31, 16'h0000);
      for (int b = 0; b < COORD_W; b++) begin
         push_voxel(5'd1 << b, 5'd0, 5'd0, 16'hAAAA);
         push_voxel(5'd0, 5'd1 << b, 5'd0, 16'h5555);
         push_voxel(5'd0, 5'd0, 5'd1 << b, 16'hFFFF);
      end
   endtask

   // small random cubes: shared paths and many duplicates
   task automatic test_clustered(input int count);
      logic [COORD_W-1:0] bx, by, bz;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            bx = COORD_W'($urandom);
            by = COORD_W'($urandom);
            bz = COORD_W'($urandom);
         end
         push_voxel(COORD_W'(bx + $urandom_range(0, 3)), COORD_W'(by + $urandom_range(0, 3)),
                    COORD_W'(bz + $urandom_range(0, 3)), COLOR_W'($urandom));
      end
   endtask

   // voxels anywhere in the chunk, allocating many nodes
   task automatic test_spread(input int count);
      for (int i = 0; i < count; i++)
         push_voxel(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                    COLOR_W'($urandom));
   endtask

   // filled voxels again with new colors, mixed with fresh ones
   task automatic test_revisit(input int count);
      req_type old;
      for (int i = 0; i < count; i++) begin
         if (filled_spots.size() != 0 && $urandom_range(0, 3) != 0) begin
            old = filled_spots[$urandom_range(0, filled_spots.size() - 1)];
            push_voxel(old.pos_x, old.pos_y, old.pos_z, COLOR_W'($urandom));
         end else begin
            push_voxel(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                       COLOR_W'($urandom));
         end
      end
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure(input int count);
      idle_on      = 1'b0;
      hold_request = 300;
      test_spread(count);
      idle_on = 1'b1;
   endtask

   // no gaps on either side
   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      test_revisit(count);
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_clustered(500);
      test_spread(800);
      test_backpressure(60);
      test_back_to_back(150);
      test_revisit(400);
      req_valid <= 1'b0;
      while (insert_outcomes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (insert_outcomes.size() != 0)
         report_mismatch("responses still outstanding at end of run");
      $display("%0d requests: %0d inserted, %0d duplicate, %0d pool exhausted",
               request_count, inserted_count, dup_count, exhaust_count);
      $display("tree ended at %0d nodes, %0d leaves; input stalled %0d cycles",
               tree_nodes, tree_leaves, stall_cycles);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("timeout with %0d responses outstanding", insert_outcomes.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
